### src/tchp_pkg.sv
// ----------------------------------------------------------------------------
// tchp_pkg
// shared types and constants of the three-channel heater controller
// ----------------------------------------------------------------------------
`default_nettype none

package tchp_pkg;

   localparam int TEMP_W  = 12;
   localparam int ERR_W   = 13;
   localparam int GAIN_W  = 16;
   localparam int SP_W    = 11;
   localparam int DUTY_W  = 10;
   localparam int ACC_W   = 40;   // serial product / term width
   localparam int INT_W   = 24;
   localparam int DER_W   = 32;
   localparam int CSR_W   = 16;
   localparam int CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_PROP_GAIN  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INTEG_GAIN = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DERIV_GAIN = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SET_POINT  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_HIGH_LIMIT = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_LOW_LIMIT  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_DUTY   = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_LOW_DUTY   = 3'd7;

   localparam logic signed [ACC_W-1:0] PCT_FULL = 40'sd6553600;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_SCALE,
      ST_DONE
   } state_type;

endpackage : tchp_pkg

`default_nettype wire

### src/three_channel_heater_pid.sv
// ----------------------------------------------------------------------------
// three_channel_heater_pid
// per-channel pid heater controller with clamped integral and filtered
// derivative, computed with bit-serial multipliers and dividers
// ----------------------------------------------------------------------------
// channel  direction  handshake          payload
// req      in         req_valid/stall    req_temp_a/b/c, req_heating_on
// rsp      out        rsp_valid/stall    rsp_duty_a/b/c, rsp_temps_ok
// csr      in         csr_write_en       csr_index, csr_data
//
// a beat is worked channel by channel: three shift-add multiplies run
// together, then a 40-step restoring divide by 20 (derivative filter), a
// 20-step divide by the set point (deviation check) and a 17-step divide
// by 100 (duty scaling), all one bit per cycle; ST_DONE then loads the
// output register, and the next beat is taken in ST_IDLE once the result
// has left
// reset (synchronous) restores the register defaults and controller state
// a result waits in the output register while rsp_stall is high; the next
// req beat is taken only after that result has left
// ----------------------------------------------------------------------------
`default_nettype none

module three_channel_heater_pid #(
   parameter int HI_DUTY       = 90,
   parameter int DEVIATION_PCT = 5
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic signed [tchp_pkg::TEMP_W-1:0] req_temp_a,
   input  wire logic signed [tchp_pkg::TEMP_W-1:0] req_temp_b,
   input  wire logic signed [tchp_pkg::TEMP_W-1:0] req_temp_c,
   input  wire logic                               req_heating_on,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic [tchp_pkg::DUTY_W-1:0]             rsp_duty_a,
   output logic [tchp_pkg::DUTY_W-1:0]             rsp_duty_b,
   output logic [tchp_pkg::DUTY_W-1:0]             rsp_duty_c,
   output logic                                    rsp_temps_ok,
   input  wire logic                               csr_write_en,
   input  wire logic [tchp_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [tchp_pkg::CSR_W-1:0]         csr_data
);
   import tchp_pkg::*;

   localparam int NCH   = 3;
   localparam int DIV_W = ACC_W;

   // last count of each divide: the count right after its final step
   localparam logic [5:0] DER_DONE = 6'd41;
   localparam logic [5:0] DEV_DONE = 6'd21;
   localparam logic [5:0] SCL_DONE = 6'd19;

   // configuration registers
   logic [GAIN_W-1:0]        prop_gain_ff, integ_gain_ff, deriv_gain_ff;
   logic [SP_W-1:0]          set_point_ff;
   logic signed [TEMP_W-1:0] high_limit_ff, low_limit_ff;
   logic [DUTY_W-1:0]        max_duty_ff, low_duty_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff  <= 16'd256;
         integ_gain_ff <= '0;
         deriv_gain_ff <= '0;
         set_point_ff  <= 11'd100;
         high_limit_ff <= 12'sd2047;
         low_limit_ff  <= -12'sd2048;
         max_duty_ff   <= 10'd100;
         low_duty_ff   <= '0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_PROP_GAIN:  prop_gain_ff  <= csr_data;
            CSR_INTEG_GAIN: integ_gain_ff <= csr_data;
            CSR_DERIV_GAIN: deriv_gain_ff <= csr_data;
            CSR_SET_POINT:  set_point_ff  <= csr_data[SP_W-1:0];
            CSR_HIGH_LIMIT: high_limit_ff <= csr_data[TEMP_W-1:0];
            CSR_LOW_LIMIT:  low_limit_ff  <= csr_data[TEMP_W-1:0];
            CSR_MAX_DUTY:   max_duty_ff   <= csr_data[DUTY_W-1:0];
            CSR_LOW_DUTY:   low_duty_ff   <= csr_data[DUTY_W-1:0];
         endcase
      end
   end

   // controller state per channel
   logic signed [ERR_W-1:0] err_now_ff [NCH];
   logic [INT_W-1:0]        integ_ff   [NCH];
   logic signed [DER_W-1:0] deriv_ff   [NCH];
   logic [DUTY_W-1:0]       held_ff    [NCH];
   logic                    first_ff;

   // captured beat
   logic signed [TEMP_W-1:0] temp_ff [NCH];
   logic                     heat_ff;

   // sequencer
   state_type state_ff, state_in;
   logic [1:0] ch_ff;
   logic [5:0] cnt_ff;
   logic [1:0] phase_ff;   // within ST_DIV: 0 deriv, 1 deviation

   // serial multiplier operands: gain bits shift out lsb first
   logic [GAIN_W-1:0]       mgp_ff, mgi_ff, mgd_ff;
   logic signed [ACC_W-1:0] mcp_ff, mci_ff, mcd_ff;   // shifted multiplicands
   logic signed [ACC_W-1:0] accp_ff, acci_ff, accd_ff;

   // serial divider (restoring, unsigned magnitude)
   logic [DIV_W-1:0] dq_ff;       // dividend shifting into quotient
   logic [DIV_W-1:0] drem_ff;
   logic [DIV_W-1:0] ddiv_ff;
   logic             dneg_ff;
   logic             ok_ff;
   logic signed [ERR_W-1:0] err_ff;

   // output register
   logic [DUTY_W-1:0] out_duty_ff [NCH];
   logic              out_ok_ff;
   logic              rsp_valid_ff;
   logic [6:0]        pct_ff;

   logic signed [TEMP_W-1:0] temp_cur;
   logic signed [ERR_W-1:0]  err_cur;
   logic signed [ERR_W:0]    diff_cur;
   logic [ERR_W-1:0]         mag_cur;
   logic [DIV_W-1:0]         rem_try;
   logic signed [ACC_W-1:0]  delta_cur, integ_sum, duty_sum, d_new;
   logic signed [ACC_W-1:0]  q_signed;
   logic [16:0]              s_wide;
   logic [DUTY_W-1:0]        s_cur, duty_next;
   logic                     take;

   assign temp_cur = temp_ff[ch_ff];
   assign err_cur  = (heat_ff ? $signed({2'b00, set_point_ff}) : 13'sd0)
                     - ERR_W'(temp_cur);
   // error step spans twice the error range
   assign diff_cur = first_ff ? '0
                     : (ERR_W+1)'(err_cur) - (ERR_W+1)'(err_now_ff[ch_ff]);
   assign mag_cur  = err_cur[ERR_W-1] ? ERR_W'(-err_cur) : ERR_W'(err_cur);
   assign rem_try  = {drem_ff[DIV_W-2:0], dq_ff[DIV_W-1]} - ddiv_ff;

   assign take      = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE) || rsp_valid_ff;

   // derivative delta and term sums
   assign delta_cur = accd_ff - ACC_W'(deriv_ff[ch_ff]);
   assign integ_sum = ACC_W'($signed({1'b0, integ_ff[ch_ff]})) + acci_ff;
   assign q_signed  = dneg_ff ? -$signed(dq_ff) : $signed(dq_ff);
   assign d_new     = ACC_W'(deriv_ff[ch_ff]) + q_signed;
   assign duty_sum  = accp_ff
                      + ((integ_sum < 0) ? 40'sd0 : (integ_sum > PCT_FULL) ? PCT_FULL
                                                                            : integ_sum)
                      + ACC_W'(deriv_ff[ch_ff]);
   assign s_wide    = 17'(dq_ff[16:0]);
   assign s_cur     = DUTY_W'(s_wide);

   always_comb begin
      if (s_wide > 17'(HI_DUTY) || s_wide > 17'(max_duty_ff)) duty_next = max_duty_ff;
      else if (s_cur < low_duty_ff) duty_next = '0;
      else duty_next = s_cur;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (take) state_in = ST_MUL;
         ST_MUL:   if (cnt_ff == 6'd15) state_in = ST_DIV;
         ST_DIV:   if (cnt_ff == DEV_DONE && phase_ff == 2'd1) state_in = ST_SCALE;
         ST_SCALE: if (cnt_ff == SCL_DONE)
                      state_in = (ch_ff == 2'(NCH-1)) ? ST_DONE : ST_MUL;
         ST_DONE:  state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   // datapath sequencing
   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         ch_ff        <= '0;
         phase_ff     <= '0;
         for (int c = 0; c < NCH; c++) begin
            err_now_ff[c] <= '0;
            integ_ff[c]   <= '0;
            deriv_ff[c]   <= '0;
            held_ff[c]    <= 10'd100;
         end
      end else begin
         if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (take) begin
                  temp_ff[0] <= req_temp_a;
                  temp_ff[1] <= req_temp_b;
                  temp_ff[2] <= req_temp_c;
                  heat_ff    <= req_heating_on;
                  ch_ff      <= '0;
                  ok_ff      <= 1'b1;
               end
               cnt_ff <= '0;
            end
            ST_MUL: begin
               // load on first step, then shift-add one gain bit per cycle
               if (cnt_ff == 6'd0) begin
                  err_ff  <= err_cur;
                  mcp_ff  <= ACC_W'(err_cur) <<< 9;
                  mci_ff  <= ACC_W'(err_cur) <<< 9;
                  mcd_ff  <= ACC_W'(diff_cur) <<< 9;
                  mgp_ff  <= prop_gain_ff >> 1;
                  mgi_ff  <= integ_gain_ff >> 1;
                  mgd_ff  <= deriv_gain_ff >> 1;
                  accp_ff <= prop_gain_ff[0]  ? ACC_W'(err_cur) <<< 8 : '0;
                  acci_ff <= integ_gain_ff[0] ? ACC_W'(err_cur) <<< 8 : '0;
                  accd_ff <= deriv_gain_ff[0] ? ACC_W'(diff_cur) <<< 8 : '0;
               end else begin
                  if (mgp_ff[0]) accp_ff <= accp_ff + mcp_ff;
                  if (mgi_ff[0]) acci_ff <= acci_ff + mci_ff;
                  if (mgd_ff[0]) accd_ff <= accd_ff + mcd_ff;
                  mgp_ff <= mgp_ff >> 1;
                  mgi_ff <= mgi_ff >> 1;
                  mgd_ff <= mgd_ff >> 1;
                  mcp_ff <= mcp_ff <<< 1;
                  mci_ff <= mci_ff <<< 1;
                  mcd_ff <= mcd_ff <<< 1;
               end
               if (cnt_ff == 6'd15) begin
                  cnt_ff   <= '0;
                  phase_ff <= '0;
               end else begin
                  cnt_ff <= cnt_ff + 6'd1;
               end
            end
            ST_DIV: begin
               if (cnt_ff == 6'd0) begin
                  drem_ff <= '0;
                  if (phase_ff == 2'd0) begin
                     // |delta| stays below 2^37 for gains and errors in range
                     dneg_ff <= delta_cur[ACC_W-1];
                     dq_ff   <= delta_cur[ACC_W-1] ? DIV_W'(-delta_cur)
                                                   : DIV_W'(delta_cur);
                     ddiv_ff <= DIV_W'(20);
                  end else begin
                     // 19-bit dividend at the top, 20 steps bring the quotient down
                     dneg_ff <= 1'b0;
                     dq_ff   <= DIV_W'(19'(mag_cur) * 19'(100)) << (DIV_W - 20);
                     ddiv_ff <= DIV_W'(set_point_ff);
                  end
                  cnt_ff <= 6'd1;
               end else if (phase_ff == 2'd0 && cnt_ff == DER_DONE) begin
                  // derivative quotient complete after 40 steps
                  deriv_ff[ch_ff] <= (d_new > 40'sh007FFFFFFF) ? 32'sh7FFFFFFF :
                                     (d_new < -40'sh0080000000) ? 32'sh80000000 :
                                     DER_W'(d_new);
                  cnt_ff   <= '0;
                  phase_ff <= 2'd1;
               end else if (phase_ff == 2'd1 && cnt_ff == DEV_DONE) begin
                  if (set_point_ff == '0 || dq_ff >= DIV_W'(DEVIATION_PCT)) ok_ff <= 1'b0;
                  cnt_ff <= '0;
               end else begin
                  if (rem_try[DIV_W-1] == 1'b0) begin
                     drem_ff <= rem_try;
                     dq_ff   <= {dq_ff[DIV_W-2:0], 1'b1};
                  end else begin
                     drem_ff <= {drem_ff[DIV_W-2:0], dq_ff[DIV_W-1]};
                     dq_ff   <= {dq_ff[DIV_W-2:0], 1'b0};
                  end
                  cnt_ff <= cnt_ff + 6'd1;
               end
            end
            ST_SCALE: begin
               if (cnt_ff == 6'd0) begin
                  pct_ff <= (duty_sum < 0) ? 7'd0 : (duty_sum > PCT_FULL) ? 7'd100
                                              : 7'(duty_sum >>> 16);
                  integ_ff[ch_ff] <= (integ_sum < 0) ? '0 : (integ_sum > PCT_FULL)
                                     ? INT_W'(PCT_FULL) : INT_W'(integ_sum);
                  err_now_ff[ch_ff] <= err_ff;
                  cnt_ff <= 6'd1;
               end else if (cnt_ff == 6'd1) begin
                  // 17-bit product at the top, 17 steps
                  dq_ff   <= DIV_W'(17'(pct_ff) * 17'(max_duty_ff)) << (DIV_W - 17);
                  drem_ff <= '0;
                  ddiv_ff <= DIV_W'(100);
                  cnt_ff  <= 6'd2;
               end else if (cnt_ff < SCL_DONE) begin
                  if (rem_try[DIV_W-1] == 1'b0) begin
                     drem_ff <= rem_try;
                     dq_ff   <= {dq_ff[DIV_W-2:0], 1'b1};
                  end else begin
                     drem_ff <= {drem_ff[DIV_W-2:0], dq_ff[DIV_W-1]};
                     dq_ff   <= {dq_ff[DIV_W-2:0], 1'b0};
                  end
                  cnt_ff <= cnt_ff + 6'd1;
               end else begin
                  if (temp_cur > high_limit_ff) held_ff[ch_ff] <= '0;
                  else if (temp_cur < low_limit_ff) held_ff[ch_ff] <= max_duty_ff;
                  else if (temp_cur < high_limit_ff) held_ff[ch_ff] <= duty_next;
                  cnt_ff <= '0;
                  ch_ff  <= ch_ff + 2'd1;
               end
            end
            ST_DONE: begin
               for (int c = 0; c < NCH; c++) out_duty_ff[c] <= held_ff[c];
               out_ok_ff    <= ok_ff;
               rsp_valid_ff <= 1'b1;
               first_ff     <= 1'b0;
            end
            default: ;
         endcase
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_duty_a   = out_duty_ff[0];
   assign rsp_duty_b   = out_duty_ff[1];
   assign rsp_duty_c   = out_duty_ff[2];
   assign rsp_temps_ok = out_ok_ff;

endmodule : three_channel_heater_pid

`default_nettype wire

### src/tchp_checker.sv
// ----------------------------------------------------------------------------
// tchp_checker
// port-level checks of the heater controller
// ----------------------------------------------------------------------------
`default_nettype none

module tchp_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_stall,
   input wire logic rsp_valid,
   input wire logic rsp_stall
);

   // no beat taken while a result is pending
   a_no_take_pending: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("req taken with result pending");

   // a result appears only after the block was busy
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall)) else $error("result without work");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid) else $error("result dropped");

   // busy right after a beat is taken
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall) else $error("not busy after take");

endmodule : tchp_checker

bind three_channel_heater_pid tchp_checker u_tchp_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall)
);

`default_nettype wire

### tb/three_channel_heater_pid_test.sv
// ----------------------------------------------------------------------------
// three_channel_heater_pid_test
// self-checking bench: a scoreboard predicts every duty beat from the
// temperatures, the heating flag and the register settings, and the bench
// drives directed and random beats under several register settings and
// idle/stall patterns
// ----------------------------------------------------------------------------
`default_nettype none

// expected result of one control period
typedef struct {
   logic [tchp_pkg::DUTY_W-1:0] duty [3];
   logic                        ok;
} heater_beat_t;

class heater_scoreboard;
   localparam int HI_DUTY       = 90;
   localparam int DEVIATION_PCT = 5;
   localparam longint FULL_PCT  = 100 * 65536;

   // register copies
   longint prop_gain, integ_gain, deriv_gain, set_point;
   longint high_limit, low_limit, max_duty, low_duty;
   // controller state
   longint err_now [3];
   longint integ_acc [3];
   longint deriv_acc [3];
   longint duty_held [3];
   bit     first_period;

   heater_beat_t pending [$];
   int mismatches;

   function new();
      mismatches = 0;
      clear();
   endfunction

   function void clear();
      prop_gain = 256; integ_gain = 0; deriv_gain = 0; set_point = 100;
      high_limit = 2047; low_limit = -2048; max_duty = 100; low_duty = 0;
      for (int c = 0; c < 3; c++) begin
         err_now[c] = 0; integ_acc[c] = 0; deriv_acc[c] = 0; duty_held[c] = 100;
      end
      first_period = 1;
      pending.delete();
   endfunction

   function void set_reg(logic [tchp_pkg::CSR_IDX_W-1:0] idx,
                         logic [tchp_pkg::CSR_W-1:0] val);
      case (idx)
         tchp_pkg::CSR_PROP_GAIN:  prop_gain  = val;
         tchp_pkg::CSR_INTEG_GAIN: integ_gain = val;
         tchp_pkg::CSR_DERIV_GAIN: deriv_gain = val;
         tchp_pkg::CSR_SET_POINT:  set_point  = val[10:0];
         tchp_pkg::CSR_HIGH_LIMIT: high_limit = longint'($signed(val[11:0]));
         tchp_pkg::CSR_LOW_LIMIT:  low_limit  = longint'($signed(val[11:0]));
         tchp_pkg::CSR_MAX_DUTY:   max_duty   = val[9:0];
         tchp_pkg::CSR_LOW_DUTY:   low_duty   = val[9:0];
         default: ;
      endcase
   endfunction

   static function longint clip(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   // one accepted period: advance the controller and queue its duties
   function void note_period(logic signed [11:0] ta, logic signed [11:0] tb,
                             logic signed [11:0] tc, logic heat);
      heater_beat_t exp_beat;
      longint temp [3];
      longint target, err, prev, mag, p, delta, d, duty, pct, s;
      temp[0] = ta; temp[1] = tb; temp[2] = tc;
      target = heat ? set_point : 0;
      exp_beat.ok = 1;
      for (int c = 0; c < 3; c++) begin
         err = target - temp[c];
         prev = first_period ? err : err_now[c];
         err_now[c] = err;
         mag = (err < 0) ? -err : err;
         if (set_point == 0 || (mag * 100) / set_point >= DEVIATION_PCT)
            exp_beat.ok = 0;
         integ_acc[c] = clip(integ_acc[c] + integ_gain * err * 256, 0, FULL_PCT);
         p = prop_gain * err * 256;
         delta = deriv_gain * (err - prev) * 256 - deriv_acc[c];
         d = clip(deriv_acc[c] + delta / 20, -64'sd2147483648, 64'sd2147483647);
         deriv_acc[c] = d;
         duty = clip(p + integ_acc[c] + d, 0, FULL_PCT);
         pct = duty / 65536;
         if (temp[c] > high_limit) begin
            duty_held[c] = 0;
         end else if (temp[c] < low_limit) begin
            duty_held[c] = max_duty;
         end else if (temp[c] < high_limit) begin
            s = (pct * max_duty) / 100;
            if (s > HI_DUTY || s > max_duty) duty_held[c] = max_duty;
            else if (s < low_duty) duty_held[c] = 0;
            else duty_held[c] = s;
         end
         // exactly at the high limit the held duty stays
         exp_beat.duty[c] = duty_held[c][9:0];
      end
      first_period = 0;
      pending.push_back(exp_beat);
   endfunction

   function void check_beat(logic [9:0] da, logic [9:0] db, logic [9:0] dc,
                            logic ok);
      heater_beat_t e;
      if (pending.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("unexpected duty beat: %0d %0d %0d ok=%0b", da, db, dc, ok);
         return;
      end
      e = pending.pop_front();
      if (da !== e.duty[0] || db !== e.duty[1] || dc !== e.duty[2] || ok !== e.ok)
      begin
         mismatches++;
         if (mismatches <= 10)
            $display("duty mismatch: exp %0d %0d %0d ok=%0b, got %0d %0d %0d ok=%0b",
                     e.duty[0], e.duty[1], e.duty[2], e.ok, da, db, dc, ok);
      end
   endfunction
endclass

module three_channel_heater_pid_test;
   timeunit 1ns;
   timeprecision 1ps;
   import tchp_pkg::*;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic signed [TEMP_W-1:0] req_temp_a = '0, req_temp_b = '0, req_temp_c = '0;
   logic req_heating_on = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic [DUTY_W-1:0] rsp_duty_a, rsp_duty_b, rsp_duty_c;
   logic rsp_temps_ok;
   logic csr_write_en = 0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0] csr_data = '0;

   heater_scoreboard period_board = new();

   // idle percentages for the current phase
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;

   three_channel_heater_pid dut (.*);

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   // result side: check accepted beats, then pick the next stall value
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         period_board.check_beat(rsp_duty_a, rsp_duty_b, rsp_duty_c, rsp_temps_ok);
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   // one req beat; the valid stays high unless a gap is drawn
   task automatic send_period(logic signed [11:0] ta, logic signed [11:0] tb,
                              logic signed [11:0] tc, logic heat);
      int gap;
      if ($urandom_range(99) < send_idle_pct) begin
         gap = $urandom_range(1, 6);
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_temp_a <= ta;
      req_temp_b <= tb;
      req_temp_c <= tc;
      req_heating_on <= heat;
      do @(posedge clock); while (req_stall);
      period_board.note_period(ta, tb, tc, heat);
   endtask

   // sender holds off until every queued duty beat has come back
   task automatic drain();
      req_valid <= 0;
      while (period_board.pending.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   // caller lowers csr_write_en after the last write
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] val);
      csr_write_en <= 1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      period_board.set_reg(idx, val);
   endtask

   task automatic load_regs(int pg, int ig, int dg, int sp, int hl, int ll,
                            int md, int ld);
      write_reg(CSR_PROP_GAIN, CSR_W'(pg));
      write_reg(CSR_INTEG_GAIN, CSR_W'(ig));
      write_reg(CSR_DERIV_GAIN, CSR_W'(dg));
      write_reg(CSR_SET_POINT, CSR_W'(sp));
      write_reg(CSR_HIGH_LIMIT, CSR_W'(hl & 12'hfff));
      write_reg(CSR_LOW_LIMIT, CSR_W'(ll & 12'hfff));
      write_reg(CSR_MAX_DUTY, CSR_W'(md));
      write_reg(CSR_LOW_DUTY, CSR_W'(ld));
      csr_write_en <= 0;
   endtask

   // mostly temperatures near the set point, some anywhere in range
   function automatic logic signed [11:0] pick_temp();
      int base;
      if ($urandom_range(99) < 30) return 12'($urandom);
      base = int'(period_board.set_point) + int'($urandom_range(0, 40)) - 20;
      if ($urandom_range(9) == 0) base = int'(period_board.high_limit);
      return 12'(base);
   endfunction

   task automatic random_periods(int n);
      for (int i = 0; i < n; i++)
         send_period(pick_temp(), pick_temp(), pick_temp(), $urandom_range(9) != 0);
   endtask

   initial begin
      int sp, hl;
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: reset settings, first period derivative, field extremes
      send_period(100, 100, 100, 1);
      send_period(-2048, 2047, 0, 1);
      send_period(2047, -2048, -1, 0);
      send_period(0, 0, 0, 0);
      send_period(99, 101, 104, 1);
      send_period(96, 95, 105, 1);
      send_period(-1, 1, 2047, 1);
      drain();
      // limits, snap thresholds and the held duty at exactly the high limit
      load_regs(2560, 64, 512, 200, 300, 50, 1023, 40);
      send_period(301, 49, 300, 1);
      send_period(300, 300, 300, 1);
      send_period(150, 190, 199, 1);
      send_period(199, 198, 197, 1);
      send_period(200, 210, 250, 0);
      send_period(60, 299, 51, 1);
      drain();
      // derivative saturation with maximum gains on big swings
      load_regs(16'hffff, 16'hffff, 16'hffff, 2047, 2047, -2048, 1023, 1023);
      send_period(2047, -2048, 2047, 0);
      send_period(-2048, 2047, -2048, 1);
      send_period(2047, -2048, 2047, 0);
      send_period(-2048, 2047, 0, 1);
      drain();
      // zero set point never reports temps in band
      load_regs(0, 0, 0, 0, -2048, -2048, 0, 0);
      send_period(0, 0, 0, 1);
      send_period(-2048, 5, 2047, 0);
      drain();

      // random phases: each loads new settings and an idle pattern
      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 59; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 59; end
            default: begin send_idle_pct = 21; rsp_stall_pct = 21; end
         endcase
         sp = $urandom_range(1, 2047);
         hl = sp + $urandom_range(0, 30);
         if (hl > 2047) hl = 2047;
         if (ph == 6)
            load_regs(16'hffff, 16'hffff, 16'hffff, 2047, 2047, -2048, 1023, 1023);
         else if (ph == 7)
            load_regs(0, 0, 0, 1, -2048, -2048, 0, 0);
         else
            load_regs($urandom_range(0, 4096), $urandom_range(0, 300),
                      $urandom_range(0, 8192), sp, hl, sp - $urandom_range(0, 30),
                      $urandom_range(0, 1023), $urandom_range(0, 120));
         random_periods(205);
         drain();
      end

      if (period_board.mismatches == 0 && period_board.pending.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // watchdog
   initial begin
      #40_000_000;
      $display("FAIL");
      $finish;
   end
endmodule

`default_nettype wire

### sim.f
src/tchp_pkg.sv
src/three_channel_heater_pid.sv
src/tchp_checker.sv
tb/three_channel_heater_pid_test.sv
